/* rtl/core/linear_probe_hash_table_core_defines.svh */
// ============================================================================
// Linear probe hash table assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ============================================================================
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lpht_pkg.sv */
// ============================================================================
// Linear probe hash table package
// Sizes, command codes and item types used by the hash table core.
// ============================================================================
`default_nettype none

package lpht_pkg;

    // Store geometry
    localparam int CAPACITY  = 16;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CFG_W  = 5;

    // Byte sum and remainder datapath
    localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1);
    localparam int MOD_W = SUM_W + CNT_W;
    localparam int BC_W  = $clog2(KEY_BYTES + 1);
    localparam int KC_W  = $clog2(SUM_W + 1);

    // Only the low KEY_BYTES bytes of a key count
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (KEY_BYTES * 8)) - KEY_W'(1));

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'((10 > CAPACITY) ? CAPACITY : 10);

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
    } request_t;

    typedef struct packed {
        logic       success;
        logic [3:0] slot_index;
        logic [4:0] entry_count;
        logic       is_full;
        logic       is_empty;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/lpht_ram.sv */
// ============================================================================
// Generic single port write, single port read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/linear_probe_hash_table_core.sv */
// Sequence: a zero key, an unused command, insert into a full table or search/remove on an
//   empty one goes straight to the done strobe after accept; otherwise the key bytes are
//   summed, the sum is reduced modulo the table size, then P probes (1..table_size) each
//   read the key store and then check the slot.
// Flow: one item at a time; busy stays high through the done strobe.
// Reset: table empty, entry count zero, table size 10; the done strobe cannot be stalled.
// ============================================================================
// Linear probe hash table core
// Open addressing hash table with linear probing over a 64-bit key store.
// ============================================================================
`default_nettype none

`include "linear_probe_hash_table_core_defines.svh"

module linear_probe_hash_table_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire lpht_pkg::request_t            request,
    output logic                               done,
    output lpht_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [lpht_pkg::CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_MOD  = 6'b000100,
        S_RD   = 6'b001000,
        S_CK   = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                       cmd_reg, cmd_next;
    logic [lpht_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [lpht_pkg::KEY_W-1:0]       shift_reg, shift_next;
    logic [lpht_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [lpht_pkg::BC_W-1:0]        bcnt_reg, bcnt_next;
    logic [lpht_pkg::KC_W-1:0]        kcnt_reg, kcnt_next;
    logic [lpht_pkg::SLOT_W-1:0]      idx_reg, idx_next;
    logic [lpht_pkg::CNT_W-1:0]       pcnt_reg, pcnt_next;
    logic                             ok_reg, ok_next;
    logic [lpht_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [lpht_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [lpht_pkg::CNT_W-1:0]       size_reg, size_next;
    logic [lpht_pkg::CAPACITY-1:0]    valid_reg, valid_next;
    logic                             rd_valid_reg;

    logic                             ram_we;
    logic [lpht_pkg::KEY_W-1:0]       ram_rdata;

    logic [lpht_pkg::KEY_W-1:0]       key_in;
    logic [lpht_pkg::KEY_W-1:0]       entry;
    logic [lpht_pkg::MOD_W-1:0]       mod_shifted;
    logic [lpht_pkg::MOD_W-1:0]       mod_diff;
    logic                             mod_ge;
    logic [lpht_pkg::SUM_W-1:0]       mod_rem;
    logic [lpht_pkg::SLOT_W-1:0]      idx_inc;
    logic [lpht_pkg::CNT_W-1:0]       cfg_size;
    logic                             fail_early;

    logic                             ins_done;
    logic [lpht_pkg::CNT_W-1:0]       count_inc;

    // Key store
    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_W),
        .DEPTH (lpht_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .re    (state_reg == S_RD),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Mask the incoming key and screen items that cannot succeed
    always_comb
    begin
        key_in     = request.key & lpht_pkg::KEY_MASK;
        fail_early = (key_in == '0) || (request.command == lpht_pkg::CMD_NONE) ||
                     ((request.command == lpht_pkg::CMD_INSERT) && (count_reg == size_reg)) ||
                     ((request.command != lpht_pkg::CMD_INSERT) && (count_reg == '0));
    end

    // Clamp a written table size into 1..CAPACITY
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_size = lpht_pkg::CNT_W'(1);
        end
        else if (int'(cfg_wdata) > lpht_pkg::CAPACITY)
        begin
            cfg_size = lpht_pkg::CNT_W'(lpht_pkg::CAPACITY);
        end
        else
        begin
            cfg_size = lpht_pkg::CNT_W'(cfg_wdata);
        end
    end

    // Compare-subtract step and probe wrap
    always_comb
    begin
        entry       = rd_valid_reg ? ram_rdata : '0;
        mod_shifted = lpht_pkg::MOD_W'(size_reg) << kcnt_reg;
        mod_ge      = lpht_pkg::MOD_W'(sum_reg) >= mod_shifted;
        mod_diff    = lpht_pkg::MOD_W'(sum_reg) - mod_shifted;
        mod_rem     = mod_ge ? lpht_pkg::SUM_W'(mod_diff) : sum_reg;
        if ((lpht_pkg::CNT_W'(idx_reg) + lpht_pkg::CNT_W'(1)) == size_reg)
        begin
            idx_inc = '0;
        end
        else
        begin
            idx_inc = idx_reg + lpht_pkg::SLOT_W'(1);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        shift_next = shift_reg;
        sum_next   = sum_reg;
        bcnt_next  = bcnt_reg;
        kcnt_next  = kcnt_reg;
        idx_next   = idx_reg;
        pcnt_next  = pcnt_reg;
        ok_next    = ok_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        size_next  = size_reg;
        valid_next = valid_reg;
        ram_we     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Take a new item
                if (start)
                begin
                    cmd_next   = request.command;
                    key_next   = key_in;
                    shift_next = key_in;
                    sum_next   = '0;
                    bcnt_next  = '0;
                    ok_next    = 1'b0;
                    slot_next  = '0;
                    state_next = fail_early ? S_DONE : S_SUM;
                end
            end
            S_SUM:
            begin
                // Add one key byte per cycle
                sum_next   = sum_reg + lpht_pkg::SUM_W'(shift_reg[7:0]);
                shift_next = shift_reg >> 8;
                bcnt_next  = bcnt_reg + lpht_pkg::BC_W'(1);
                if (bcnt_reg == lpht_pkg::BC_W'(lpht_pkg::KEY_BYTES - 1))
                begin
                    kcnt_next  = lpht_pkg::KC_W'(lpht_pkg::SUM_W - 1);
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // Restoring remainder, one bit per cycle
                sum_next  = mod_rem;
                kcnt_next = kcnt_reg - lpht_pkg::KC_W'(1);
                if (kcnt_reg == '0)
                begin
                    idx_next   = lpht_pkg::SLOT_W'(mod_rem);
                    pcnt_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CK;
            end
            S_CK:
            begin
                if (cmd_reg == lpht_pkg::CMD_INSERT)
                begin
                    // Store into the first empty slot
                    if (entry == '0)
                    begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        count_next          = count_reg + lpht_pkg::CNT_W'(1);
                        ok_next             = 1'b1;
                        slot_next           = idx_reg;
                        state_next          = S_DONE;
                    end
                end
                else if (entry == '0)
                begin
                    // Stop the search at an empty slot
                    state_next = S_DONE;
                end
                else if (entry == key_reg)
                begin
                    ok_next   = 1'b1;
                    slot_next = idx_reg;
                    if (cmd_reg == lpht_pkg::CMD_REMOVE)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        count_next          = count_reg - lpht_pkg::CNT_W'(1);
                    end
                    state_next = S_DONE;
                end

                // Advance to the next slot or give up after a full lap
                if (state_next == S_CK)
                begin
                    if ((pcnt_reg + lpht_pkg::CNT_W'(1)) == size_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pcnt_next  = pcnt_reg + lpht_pkg::CNT_W'(1);
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A size write starts a new, empty table
        if (cfg_we)
        begin
            size_next  = cfg_size;
            valid_next = '0;
            count_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            size_reg  <= lpht_pkg::SIZE_RESET;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            size_reg  <= size_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        shift_reg <= shift_next;
        sum_reg   <= sum_next;
        bcnt_reg  <= bcnt_next;
        kcnt_reg  <= kcnt_next;
        idx_reg   <= idx_next;
        pcnt_reg  <= pcnt_next;
        ok_reg    <= ok_next;
        slot_reg  <= slot_next;
        if (state_reg == S_RD)
        begin
            rd_valid_reg <= valid_reg[idx_reg];
        end
    end

    // Result item
    always_comb
    begin
        busy               = (state_reg != S_IDLE);
        done               = (state_reg == S_DONE);
        result.success     = ok_reg;
        result.slot_index  = 4'(slot_reg);
        result.entry_count = 5'(count_reg);
        result.is_full     = (count_reg == size_reg);
        result.is_empty    = (count_reg == '0);
    end

    // Terms for the checks
    always_comb
    begin
        ins_done  = done && result.success && (cmd_reg == lpht_pkg::CMD_INSERT);
        count_inc = count_reg + lpht_pkg::CNT_W'(1);
    end

    // Checks
    `LPHT_ASSERT_NOW(a_count_in_size, 1'b1, count_reg <= size_reg, "entry count above table size")
    `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `LPHT_ASSERT_NEXT(a_done_idle, done, !busy, "busy held after the done strobe")
    `LPHT_ASSERT_NOW(a_insert_count, ins_done, count_reg == $past(count_inc), "insert count off")

endmodule

`default_nettype wire
